/* hdl/spq_pkg.sv */
// Shared types and constants for the stable priority queue unit.
// No dependencies; imported by every module under hdl/.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int PRIO_W        = 8;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 5;
    localparam int STATUS_W      = 2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_code_t;

    // controller -> datapath
    typedef struct packed {
        logic         load;       // latch the request word
        logic         enq;        // insert the latched entry
        logic         deq;        // pop the head
        logic         wr_result;  // update the result registers
        status_code_t code;
    } spq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_deq;
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

/* hdl/spq_datapath.sv */
// Sorted entry row, request register and result registers of the queue.
// Depends on spq_pkg; driven by spq_controller through spq_cmd_t.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  spq_cmd_t                 cmd,
    output spq_stat_t                stat,
    input  logic                     op,
    input  logic signed [DATA_W-1:0] item_data,
    input  logic [PRIO_W-1:0]        item_priority,
    output logic [STATUS_W-1:0]      status,
    output logic [PRIO_W-1:0]        out_priority,
    output logic signed [DATA_W-1:0] out_data,
    output logic [COUNT_W-1:0]       count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                     op_reg;
    logic [PRIO_W-1:0]        req_prio_reg;
    logic signed [DATA_W-1:0] req_data_reg;

    logic [PRIO_W-1:0]        prio_reg  [DEPTH];
    logic [PRIO_W-1:0]        prio_next [DEPTH];
    logic [PRIO_W-1:0]        prio_up   [DEPTH];
    logic [PRIO_W-1:0]        prio_dn   [DEPTH];
    logic signed [DATA_W-1:0] data_reg  [DEPTH];
    logic signed [DATA_W-1:0] data_next [DEPTH];
    logic signed [DATA_W-1:0] data_up   [DEPTH];
    logic signed [DATA_W-1:0] data_dn   [DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [DEPTH-1:0] gt;
    logic [DEPTH-1:0] gt_prev;
    logic [DEPTH-1:0] at_end;

    logic [STATUS_W-1:0]      status_reg;
    logic [PRIO_W-1:0]        out_priority_reg;
    logic signed [DATA_W-1:0] out_data_reg;

    // neighbour taps of each cell
    always_comb
    begin
        prio_up[0] = req_prio_reg;
        data_up[0] = req_data_reg;
        for (int i = 1; i < DEPTH; i++)
        begin
            prio_up[i] = prio_reg[i-1];
            data_up[i] = data_reg[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            prio_dn[i] = prio_reg[i+1];
            data_dn[i] = data_reg[i+1];
        end
        prio_dn[DEPTH-1] = prio_reg[DEPTH-1];
        data_dn[DEPTH-1] = data_reg[DEPTH-1];
    end

    // each occupied cell compares itself with the new priority; the row is
    // sorted, so gt is a run of ones ending at the fill level
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i]     = (CNT_W'(i) < count_reg) && (prio_reg[i] > req_prio_reg);
            at_end[i] = (CNT_W'(i) == count_reg);
        end
        gt_prev = {gt[DEPTH-2:0], 1'b0};
    end

    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            prio_next[i] = prio_reg[i];
            data_next[i] = data_reg[i];
        end
        if (cmd.enq)
        begin
            count_next = count_reg + 1'b1;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (gt_prev[i])
                begin
                    prio_next[i] = prio_up[i];
                    data_next[i] = data_up[i];
                end
                else if (gt[i] || at_end[i])
                begin
                    prio_next[i] = req_prio_reg;
                    data_next[i] = req_data_reg;
                end
            end
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - 1'b1;
            for (int i = 0; i < DEPTH; i++)
            begin
                prio_next[i] = prio_dn[i];
                data_next[i] = data_dn[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            prio_reg[i] <= prio_next[i];
            data_reg[i] <= data_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op;
            req_prio_reg <= item_priority;
            req_data_reg <= item_data;
        end
        if (cmd.wr_result)
        begin
            status_reg <= cmd.code;
            if (cmd.deq)
            begin
                out_priority_reg <= prio_reg[0];
                out_data_reg     <= data_reg[0];
            end
            else
            begin
                out_priority_reg <= '0;
                out_data_reg     <= '0;
            end
        end
    end

    assign stat.op_deq = (op_reg == OP_DEQUEUE);
    assign stat.full   = (count_reg == CNT_W'(DEPTH));
    assign stat.empty  = (count_reg == '0);

    assign status       = status_reg;
    assign out_priority = out_priority_reg;
    assign out_data     = out_data_reg;
    assign count        = COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq |=> count_reg == $past(count_reg) + 1'b1)
        else $error("enqueue did not add an entry");

    a_deq_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not remove an entry");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> prio_reg[0] <= prio_reg[1])
        else $error("head entries out of order");

endmodule

/* hdl/spq_controller.sv */
// Request sequencer for the queue: handshakes and datapath commands.
// Depends on spq_pkg; steers spq_datapath.
module spq_controller
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // a new word may enter in the same cycle the pending result leaves
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.code       = ST_DONE;
        cmd.load       = accept;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.wr_result = 1'b1;
                if (stat.op_deq)
                begin
                    cmd.deq  = !stat.empty;
                    cmd.code = stat.empty ? ST_EMPTY : ST_DONE;
                end
                else
                begin
                    cmd.enq  = !stat.full;
                    cmd.code = stat.full ? ST_FULL : ST_DONE;
                end
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted word not executed");

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> out_valid_reg)
        else $error("no result after execute");

    a_no_double_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.enq && cmd.deq))
        else $error("enqueue and dequeue together");

    a_exec_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> !in_ready)
        else $error("input taken during execute");

endmodule

/* hdl/stable_priority_queue_unit.sv */
// Stable priority queue: sorted row of DEPTH cells, lowest priority number at the head.
// On accept the request word is registered and the controller enters its execute state,
// which shifts the cell row and writes the result registers and result valid. No new word
// is taken while a word executes, set by the controller's load/execute sequence; the next
// word is taken in the cycle the result leaves.
// Reset: clears the entry count, the sequencer and the result valid; entry storage is
// not cleared and only occupied cells are ever read.
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic signed [DATA_W-1:0] item_data,
    input  logic [PRIO_W-1:0]        item_priority,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [PRIO_W-1:0]        out_priority,
    output logic signed [DATA_W-1:0] out_data,
    output logic [COUNT_W-1:0]       count
);

    spq_cmd_t  cmd;
    spq_stat_t stat;

    spq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .op            (op),
        .item_data     (item_data),
        .item_priority (item_priority),
        .status        (status),
        .out_priority  (out_priority),
        .out_data      (out_data),
        .count         (count)
    );

endmodule
